// ----- rtl/idalloc_pkg.sv -----
// Package for the lowest-free ID allocator: payload structs, operation codes,
// controller states and the command/status structs between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps

package idalloc_pkg;

	// Default size of the ID space.
	localparam int ID_COUNT_DEF = 256;

	// The bitmap is stored as words of WORD_W bits.
	localparam int WORD_W = 32;
	localparam int BIT_W  = 5;

	// Operation codes carried in the func field.
	localparam logic [2:0] FUNC_ALLOC   = 3'd0;
	localparam logic [2:0] FUNC_FREE    = 3'd1;
	localparam logic [2:0] FUNC_RESERVE = 3'd2;
	localparam logic [2:0] FUNC_UPDATE  = 3'd3;
	localparam logic [2:0] FUNC_CLEAR   = 3'd4;

	typedef struct packed {
		logic [2:0] func;
		logic [7:0] id;
		logic [7:0] new_id;
	} req_t;

	typedef struct packed {
		logic [7:0] id_out;
		logic       ok;
	} rsp_t;

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_DECODE,
		ST_ALLOC_RD,
		ST_ALLOC_CHK,
		ST_RES_WR,
		ST_FREE_RD,
		ST_FREE_WR,
		ST_CLEAR
	} state_t;

	// Which ID, or the scan pointer, selects the bitmap word.
	typedef enum logic [1:0] {
		ADDR_ID,
		ADDR_NEW,
		ADDR_PTR
	} addr_sel_t;

	// How the written word is formed.
	typedef enum logic [1:0] {
		WR_ZERO,
		WR_SET,
		WR_CLR,
		WR_ALLOC
	} wr_op_t;

	typedef struct packed {
		logic      load;
		logic      rd_en;
		logic      wr_en;
		addr_sel_t addr_sel;
		wr_op_t    wr_op;
		logic      ptr_load;
		logic      ptr_inc;
		logic      wipe;
		logic      respond;
		logic      resp_ok;
		logic      resp_alloc;
	} cmd_t;

	typedef struct packed {
		logic [2:0] func;
		logic       id_ok;
		logic       new_ok;
		logic       id_taken;
		logic       new_taken;
		logic       word_full;
		logic       ptr_last;
	} status_t;

endpackage

// ----- rtl/id_allocator_with_reservations_core.sv -----
// Sequence: allocate reads bitmap words upward from the free hint until one has a free
// bit; free and reserve read and rewrite one word; update sets the new ID, then frees the old.
// Throughput: one transaction at a time; busy stays high until the result is issued, so
// the next one is taken only once the current one has finished.
// Reset: after arst_n releases, a clearing pass zeroes ceil(ID_COUNT/32) bitmap words,
// one per cycle, with busy high. The receiver cannot stall: done is a one-cycle strobe.
`timescale 1ns / 1ps

// Top level of the lowest-free ID allocator; depends on idalloc_pkg and instantiates
// idalloc_ctrl (state machine) and idalloc_dp (bitmap memory and registers).
module id_allocator_with_reservations_core
	import idalloc_pkg::*;
#(
	parameter int ID_COUNT = ID_COUNT_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  req_t req,
	output logic done,
	output rsp_t rsp
);

	// The controller sequences every transaction as reads and writes of whole bitmap
	// words. The datapath answers with flags about the latched item and the word just
	// read, so the controller never sees raw data.
	cmd_t    cmd;
	status_t status;

	idalloc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.status (status),
		.cmd    (cmd)
	);

	// The datapath keeps the taken bits in a word memory, a scan pointer that starts
	// at the lowest word that may hold a free ID, and the high-water mark, which is
	// kept as state but drives no output.
	idalloc_dp #(
		.ID_COUNT (ID_COUNT)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.status (status),
		.done   (done),
		.rsp    (rsp)
	);

endmodule

// ----- rtl/idalloc_ctrl.sv -----
// Controller state machine of the ID allocator.
// Depends on idalloc_pkg; drives the datapath (idalloc_dp) through cmd_t.
`timescale 1ns / 1ps

module idalloc_ctrl
	import idalloc_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	output logic    busy,
	input  status_t status,
	output cmd_t    cmd
);

	state_t state_q;
	state_t state_d;
	logic   is_upd;
	logic   tgt_taken;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	assign is_upd    = (status.func == FUNC_UPDATE);
	assign tgt_taken = is_upd ? status.new_taken : status.id_taken;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.addr_sel = ADDR_PTR;
		cmd.wr_op    = WR_ZERO;
		busy    = (state_q != ST_IDLE);
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load     = 1'b1;
					cmd.ptr_load = 1'b1;
					state_d      = ST_DECODE;
				end
			end
			ST_DECODE: begin
				case (status.func)
					FUNC_ALLOC: begin
						cmd.rd_en = 1'b1;
						state_d   = ST_ALLOC_CHK;
					end
					FUNC_FREE: begin
						if (status.id_ok) begin
							cmd.rd_en    = 1'b1;
							cmd.addr_sel = ADDR_ID;
							state_d      = ST_FREE_WR;
						end else begin
							cmd.respond = 1'b1;
							cmd.resp_ok = 1'b1;
							state_d     = ST_IDLE;
						end
					end
					FUNC_RESERVE: begin
						if (status.id_ok) begin
							cmd.rd_en    = 1'b1;
							cmd.addr_sel = ADDR_ID;
							state_d      = ST_RES_WR;
						end else begin
							cmd.respond = 1'b1;
							state_d     = ST_IDLE;
						end
					end
					FUNC_UPDATE: begin
						if (status.new_ok) begin
							cmd.rd_en    = 1'b1;
							cmd.addr_sel = ADDR_NEW;
							state_d      = ST_RES_WR;
						end else begin
							cmd.respond = 1'b1;
							state_d     = ST_IDLE;
						end
					end
					FUNC_CLEAR: begin
						cmd.wipe = 1'b1;
						state_d  = ST_CLEAR;
					end
					default: begin
						cmd.respond = 1'b1;
						state_d     = ST_IDLE;
					end
				endcase
			end
			ST_ALLOC_RD: begin
				cmd.rd_en = 1'b1;
				state_d   = ST_ALLOC_CHK;
			end
			ST_ALLOC_CHK: begin
				if (!status.word_full) begin
					cmd.wr_en      = 1'b1;
					cmd.wr_op      = WR_ALLOC;
					cmd.respond    = 1'b1;
					cmd.resp_ok    = 1'b1;
					cmd.resp_alloc = 1'b1;
					state_d        = ST_IDLE;
				end else if (status.ptr_last) begin
					cmd.respond = 1'b1;
					state_d     = ST_IDLE;
				end else begin
					cmd.ptr_inc = 1'b1;
					state_d     = ST_ALLOC_RD;
				end
			end
			ST_RES_WR: begin
				if (tgt_taken) begin
					cmd.respond = 1'b1;
					state_d     = ST_IDLE;
				end else begin
					cmd.wr_en    = 1'b1;
					cmd.wr_op    = WR_SET;
					cmd.addr_sel = is_upd ? ADDR_NEW : ADDR_ID;
					if (is_upd && status.id_ok) begin
						state_d = ST_FREE_RD;
					end else begin
						cmd.respond = 1'b1;
						cmd.resp_ok = 1'b1;
						state_d     = ST_IDLE;
					end
				end
			end
			ST_FREE_RD: begin
				cmd.rd_en    = 1'b1;
				cmd.addr_sel = ADDR_ID;
				state_d      = ST_FREE_WR;
			end
			ST_FREE_WR: begin
				cmd.wr_en    = 1'b1;
				cmd.wr_op    = WR_CLR;
				cmd.addr_sel = ADDR_ID;
				cmd.respond  = 1'b1;
				cmd.resp_ok  = 1'b1;
				state_d      = ST_IDLE;
			end
			ST_INIT, ST_CLEAR: begin
				cmd.wr_en = 1'b1;
				if (status.ptr_last) begin
					cmd.respond = (state_q == ST_CLEAR);
					cmd.resp_ok = 1'b1;
					state_d     = ST_IDLE;
				end else begin
					cmd.ptr_inc = 1'b1;
				end
			end
			default: begin
				state_d = ST_INIT;
			end
		endcase
	end

	// An accepted transaction always keeps the block busy in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n) start && !busy |=> busy)
		else $error("busy not raised after an accepted transaction");

	// The allocation check always consumes a word read issued in the cycle before.
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ALLOC_CHK |-> $past(cmd.rd_en))
		else $error("allocation check without a preceding word read");

	// The word memory has a single port, so a read and a write never share a cycle.
	assert property (@(posedge clk) disable iff (!arst_n) !(cmd.rd_en && cmd.wr_en))
		else $error("word read and write in the same cycle");

endmodule

// ----- rtl/idalloc_dp.sv -----
// Datapath of the ID allocator: bitmap word memory, scan pointer, free hint,
// high-water mark, item and result registers. Depends on idalloc_pkg.
`timescale 1ns / 1ps

module idalloc_dp
	import idalloc_pkg::*;
#(
	parameter int ID_COUNT = ID_COUNT_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  req_t    req,
	input  cmd_t    cmd,
	output status_t status,
	output logic    done,
	output rsp_t    rsp
);

	localparam int WORDS     = (ID_COUNT + WORD_W - 1) / WORD_W;
	localparam int ADDR_W    = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int AID_W     = ADDR_W + BIT_W;
	localparam int MARK_W    = $clog2(ID_COUNT + 1);
	localparam int LAST_BITS = ID_COUNT - (WORDS - 1) * WORD_W;
	localparam logic [WORD_W-1:0] PAD_MASK =
		~WORD_W'((64'd1 << LAST_BITS) - 64'd1);

	logic [WORD_W-1:0] mem [WORDS];
	logic [WORD_W-1:0] rdata_q;

	logic [2:0]        func_q;
	logic [7:0]        id_q;
	logic [7:0]        new_id_q;

	logic [ADDR_W-1:0] ptr_q;
	logic [ADDR_W-1:0] hint_q;
	logic [MARK_W-1:0] high_mark_q;
	logic              done_q;
	rsp_t              rsp_q;

	logic [ADDR_W-1:0] id_word;
	logic [ADDR_W-1:0] new_word;
	logic [ADDR_W-1:0] addr;
	logic [BIT_W-1:0]  sel_bit;
	logic [WORD_W-1:0] sel_1h;
	logic [WORD_W-1:0] free_v;
	logic [WORD_W-1:0] low_1h;
	logic [BIT_W-1:0]  enc;
	logic [AID_W-1:0]  alloc_id;
	logic [WORD_W-1:0] wdata;
	logic              ptr_last;

	assign id_word  = ADDR_W'({8'd0, id_q} >> BIT_W);
	assign new_word = ADDR_W'({8'd0, new_id_q} >> BIT_W);
	assign ptr_last = (ptr_q == ADDR_W'(WORDS - 1));

	always_comb begin
		case (cmd.addr_sel)
			ADDR_ID: begin
				addr    = id_word;
				sel_bit = id_q[BIT_W-1:0];
			end
			ADDR_NEW: begin
				addr    = new_word;
				sel_bit = new_id_q[BIT_W-1:0];
			end
			default: begin
				addr    = ptr_q;
				sel_bit = id_q[BIT_W-1:0];
			end
		endcase
	end

	assign sel_1h = WORD_W'(1) << sel_bit;

	// Lowest free bit of the scanned word; padding past the ID space reads as taken.
	assign free_v = ~(rdata_q | (ptr_last ? PAD_MASK : '0));
	assign low_1h = free_v & (~free_v + WORD_W'(1));

	always_comb begin
		enc = '0;
		for (int i = 0; i < WORD_W; i++) begin
			if (low_1h[i]) begin
				enc = enc | BIT_W'(i);
			end
		end
	end

	assign alloc_id = {ptr_q, enc};

	always_comb begin
		case (cmd.wr_op)
			WR_SET:   wdata = rdata_q | sel_1h;
			WR_CLR:   wdata = rdata_q & ~sel_1h;
			WR_ALLOC: wdata = rdata_q | low_1h;
			default:  wdata = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem[addr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			rdata_q <= mem[addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q   <= req.func;
			id_q     <= req.id;
			new_id_q <= req.new_id;
		end
		if (cmd.respond) begin
			rsp_q.ok     <= cmd.resp_ok;
			rsp_q.id_out <= cmd.resp_alloc ? 8'(alloc_id) : 8'd0;
		end
	end

	// Every word below hint_q is full, so a scan may start there.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q       <= '0;
			hint_q      <= '0;
			high_mark_q <= '0;
			done_q      <= 1'b0;
		end else begin
			done_q <= cmd.respond;
			if (cmd.wipe) begin
				ptr_q       <= '0;
				hint_q      <= '0;
				high_mark_q <= '0;
			end else begin
				if (cmd.ptr_load) begin
					ptr_q <= hint_q;
				end else if (cmd.ptr_inc) begin
					ptr_q <= ptr_q + ADDR_W'(1);
				end
				if (cmd.wr_en && cmd.wr_op == WR_ALLOC) begin
					hint_q <= ptr_q;
					if (17'(alloc_id) >= 17'(high_mark_q)) begin
						high_mark_q <= MARK_W'(17'(alloc_id) + 17'd1);
					end
				end else if (cmd.wr_en && cmd.wr_op == WR_CLR && addr < hint_q) begin
					hint_q <= addr;
				end
			end
		end
	end

	assign status.func      = func_q;
	assign status.id_ok     = (17'(id_q) < 17'(ID_COUNT));
	assign status.new_ok    = (17'(new_id_q) < 17'(ID_COUNT));
	assign status.id_taken  = rdata_q[id_q[BIT_W-1:0]];
	assign status.new_taken = rdata_q[new_id_q[BIT_W-1:0]];
	assign status.word_full = (free_v == '0);
	assign status.ptr_last  = ptr_last;

	assign done = done_q;
	assign rsp  = rsp_q;

	// The watermark never passes the size of the ID space.
	assert property (@(posedge clk) disable iff (!arst_n)
		17'(high_mark_q) <= 17'(ID_COUNT))
		else $error("high-water mark beyond the ID space");

	// An allocation writes exactly one new bit into the scanned word.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_en && cmd.wr_op == WR_ALLOC |-> $onehot(low_1h))
		else $error("allocation without a single free bit");

	// The scan never starts below the free hint.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_en && cmd.wr_op == WR_ALLOC |-> hint_q <= ptr_q)
		else $error("allocation scan below the free hint");

endmodule
